FILE: rtl/msls_pkg.sv
package msls_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = $clog2(MAX_SERVERS);
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int CFG_W       = 5;
    localparam int DUR_W       = 16;
    localparam int TIME_W      = 48;
    localparam int JOBS_W      = 32;
    localparam int OUT_W       = 2 * TIME_W + JOBS_W;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [JOBS_W-1:0] JOBS_MAX = {JOBS_W{1'b1}};

    typedef logic [TIME_W-1:0] t_time;

    function automatic t_time sat_add(input t_time a, input t_time b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

FILE: rtl/multi_server_list_scheduler_top.sv
// channel  | direction | word contents (lsb first)                 | handshake
// ---------+-----------+-------------------------------------------+------------------------
// s        | in        | tdata: duration[15:0]; tlast: last_job    | i_s_tvalid / o_s_tready
// m        | out       | tdata: makespan, total_wait, job_count    | o_m_tvalid / i_m_tready
// cfg      | in        | server_count[4:0]                         | i_cfg_valid / o_cfg_ready
//
// a job that fills an idle server goes straight to the final step; a later job scans
// the filled servers (one compare per cycle through the finish time store, then the
// update), with up to 16 servers in use
// a last job waits in the final step while an earlier result is still not taken
// synchronous active-low reset clears the batch counters and sets server_count to 1
module multi_server_list_scheduler_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [msls_pkg::DUR_W-1:0]         i_s_tdata,   // duration
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [msls_pkg::OUT_W-1:0]         o_m_tdata,   // makespan, total_wait, job_count
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [msls_pkg::CFG_W-1:0]         i_cfg_data   // server_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FIN
    } t_state;

    t_state                        r_state;
    msls_pkg::t_time               r_ft [msls_pkg::MAX_SERVERS];
    logic [msls_pkg::CFG_W-1:0]    r_cfg;
    logic [msls_pkg::CNT_W-1:0]    r_filled;
    msls_pkg::t_time               r_wait;
    logic [msls_pkg::JOBS_W-1:0]   r_jobs;
    msls_pkg::t_time               r_span;
    logic [msls_pkg::DUR_W-1:0]    r_dur;
    logic                          r_last;
    logic [msls_pkg::IDX_W-1:0]    r_idx;
    logic [msls_pkg::IDX_W-1:0]    r_best;
    msls_pkg::t_time               r_bestval;
    logic                          r_m_valid;
    logic [msls_pkg::OUT_W-1:0]    r_m_data;

    logic [msls_pkg::CNT_W-1:0]    n_use;
    msls_pkg::t_time               n_rd;
    msls_pkg::t_time               n_cmp_a;
    msls_pkg::t_time               n_cmp_b;
    logic                          n_less;
    msls_pkg::t_time               n_newv;
    logic                          n_accept;
    logic                          n_scan_end;
    logic                          n_emit;

    always_comb begin
        if (r_cfg == '0) begin
            n_use = msls_pkg::CNT_W'(1);
        end else if ({{(msls_pkg::CNT_W){1'b0}}, r_cfg} > msls_pkg::MAX_SERVERS) begin
            n_use = msls_pkg::CNT_W'(msls_pkg::MAX_SERVERS);
        end else begin
            n_use = msls_pkg::CNT_W'(r_cfg);
        end
    end

    assign n_rd       = r_ft[r_idx];
    assign n_newv     = msls_pkg::sat_add(r_bestval, msls_pkg::TIME_W'(r_dur));
    assign n_accept   = i_s_tvalid && o_s_tready;
    assign n_scan_end = ({1'b0, r_idx} == msls_pkg::CNT_W'(r_filled - 1'b1));
    assign n_emit     = (r_state == S_FIN) && r_last && (!r_m_valid || i_m_tready);

    // shared compare: min search during scan, running max on fill and at update
    always_comb begin
        if (r_state == S_SCAN) begin
            n_cmp_a = n_rd;
            n_cmp_b = r_bestval;
        end else if (r_state == S_IDLE) begin
            n_cmp_a = r_span;
            n_cmp_b = msls_pkg::TIME_W'(i_s_tdata);
        end else begin
            n_cmp_a = r_span;
            n_cmp_b = n_newv;
        end
    end
    assign n_less = n_cmp_a < n_cmp_b;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= msls_pkg::CFG_W'(1);
            r_filled  <= '0;
            r_wait    <= '0;
            r_jobs    <= '0;
            r_span    <= '0;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
            r_best    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (r_m_valid && i_m_tready && !n_emit) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_dur  <= i_s_tdata;
                        r_last <= i_s_tlast;
                        if (r_jobs != msls_pkg::JOBS_MAX) begin
                            r_jobs <= r_jobs + 1'b1;
                        end
                        if (r_filled < n_use) begin
                            r_ft[r_filled[msls_pkg::IDX_W-1:0]] <=
                                msls_pkg::TIME_W'(i_s_tdata);
                            r_filled <= r_filled + 1'b1;
                            if (n_less) begin
                                r_span <= msls_pkg::TIME_W'(i_s_tdata);
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_idx     <= '0;
                            r_best    <= '0;
                            r_bestval <= msls_pkg::TIME_MAX;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (n_less) begin
                        r_best    <= r_idx;
                        r_bestval <= n_rd;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (n_scan_end) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_wait       <= msls_pkg::sat_add(r_wait, r_bestval);
                    r_ft[r_best] <= n_newv;
                    if (n_less) begin
                        r_span <= n_newv;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (n_emit) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_jobs, r_wait, r_span};
                        r_filled  <= '0;
                        r_wait    <= '0;
                        r_jobs    <= '0;
                        r_span    <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/msls_checker.sv
module msls_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [msls_pkg::OUT_W-1:0]     o_m_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result word changed while stalled");

    // one job at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accepted a word while busy");

    // a reported batch holds at least one job
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[msls_pkg::OUT_W-1:2*msls_pkg::TIME_W] != '0))
        else $error("result with zero job count");

    // a new result only appears after a job was taken in
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result without a job in progress");

endmodule

bind multi_server_list_scheduler_top msls_checker u_msls_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_JOBS   = 1580;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic [msls_pkg::JOBS_W-1:0] job_count;
        msls_pkg::t_time             total_wait;
        msls_pkg::t_time             makespan;
    } t_report;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [msls_pkg::DUR_W-1:0] s_tdata  = '0;    // duration
    logic                       s_tlast  = 1'b0;  // last_job
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [msls_pkg::OUT_W-1:0] m_tdata;          // makespan, total_wait, job_count
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [msls_pkg::CFG_W-1:0] cfg_data  = '0;   // server_count

    // predicted scheduler state
    msls_pkg::t_time             finish_at [msls_pkg::MAX_SERVERS];
    int unsigned                 busy_servers  = 0;
    msls_pkg::t_time             wait_total    = '0;
    logic [msls_pkg::JOBS_W-1:0] jobs_in_batch = '0;
    logic [msls_pkg::CFG_W-1:0]  servers_cfg   = msls_pkg::CFG_W'(1);

    t_report pending_reports [$];

    int                            failures     = 0;
    int                            reports_seen = 0;
    int                            jobs_sent    = 0;
    int                            rx_stall     = 0;
    bit                            tx_quiet     = 1'b0;
    bit                            rx_quiet     = 1'b0;
    bit [(1<<msls_pkg::CFG_W)-1:0] counts_tried = '0;

    multi_server_list_scheduler_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [msls_pkg::DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 6) return msls_pkg::DUR_W'($urandom_range(0, 15));
        return msls_pkg::DUR_W'($urandom);
    endfunction

    function automatic logic [msls_pkg::CFG_W-1:0] pick_server_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1)
            return msls_pkg::CFG_W'($urandom_range(msls_pkg::MAX_SERVERS + 1,
                                                   (1 << msls_pkg::CFG_W) - 1));
        if (r < 4) return msls_pkg::CFG_W'(1);
        if (r < 7) return msls_pkg::CFG_W'(msls_pkg::MAX_SERVERS);
        return msls_pkg::CFG_W'($urandom_range(1, msls_pkg::MAX_SERVERS));
    endfunction

    function automatic int unsigned servers_active(input logic [msls_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > msls_pkg::MAX_SERVERS) return msls_pkg::MAX_SERVERS;
        return 32'(v);
    endfunction

    function automatic msls_pkg::t_time add_clamped(input msls_pkg::t_time a,
                                                    input msls_pkg::t_time b);
        if (a > msls_pkg::TIME_MAX - b) return msls_pkg::TIME_MAX;
        return a + b;
    endfunction

    task automatic predict_job(input logic [msls_pkg::DUR_W-1:0] dur, input logic last);
        int unsigned     earliest;
        msls_pkg::t_time span;
        t_report         rep;
        if (busy_servers < servers_active(servers_cfg)) begin
            finish_at[busy_servers] = msls_pkg::t_time'(dur);
            busy_servers++;
        end else begin
            // job goes to the server that frees up first
            earliest = 0;
            for (int unsigned k = 1; k < busy_servers; k++)
                if (finish_at[k] < finish_at[earliest]) earliest = k;
            wait_total = add_clamped(wait_total, finish_at[earliest]);
            finish_at[earliest] = add_clamped(finish_at[earliest], msls_pkg::t_time'(dur));
        end
        if (jobs_in_batch != msls_pkg::JOBS_MAX) jobs_in_batch = jobs_in_batch + 1'b1;
        if (last) begin
            span = '0;
            for (int unsigned k = 0; k < busy_servers; k++)
                if (finish_at[k] > span) span = finish_at[k];
            rep.makespan   = span;
            rep.total_wait = wait_total;
            rep.job_count  = jobs_in_batch;
            pending_reports = {pending_reports, rep};
            busy_servers  = 0;
            wait_total    = '0;
            jobs_in_batch = '0;
        end
    endtask

    // valid stays high after acceptance, the next send or settle decides
    task automatic send_job(input logic [msls_pkg::DUR_W-1:0] dur, input logic last);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= dur;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_job(dur, last);
        jobs_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_servers(input logic [msls_pkg::CFG_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        servers_cfg = v;
        counts_tried[v] = 1'b1;
    endtask

    always @(posedge clk) begin : take_reports
        t_report got;
        t_report want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    failures++;
                    if (failures <= MAX_SHOWN)
                        $display("unexpected report: makespan %0d total_wait %0d job_count %0d",
                                 got.makespan, got.total_wait, got.job_count);
                end else begin
                    want = pending_reports.pop_front();
                    if (got.makespan !== want.makespan || got.total_wait !== want.total_wait ||
                        got.job_count !== want.job_count) begin
                        failures++;
                        if (failures <= MAX_SHOWN)
                            $display({"report mismatch (exp/got): makespan %0d/%0d ",
                                      "total_wait %0d/%0d job_count %0d/%0d"},
                                     want.makespan, got.makespan, want.total_wait,
                                     got.total_wait, want.job_count, got.job_count);
                    end
                end
            end
            if (rx_stall != 0) begin
                rx_stall = rx_stall - 1;
                m_tready <= 1'b0;
            end else begin
                rx_stall = rx_quiet ? 0 : pick_gap();
                m_tready <= (rx_stall == 0);
            end
        end
    end

    task automatic test_single_server();
        send_job('0, 1'b1);
        send_job('1, 1'b0);
        send_job('1, 1'b1);
    endtask

    task automatic test_equal_and_zero();
        set_servers(msls_pkg::CFG_W'(3));
        send_job(msls_pkg::DUR_W'(5), 1'b0);
        send_job(msls_pkg::DUR_W'(5), 1'b0);
        send_job(msls_pkg::DUR_W'(5), 1'b0);
        send_job('0, 1'b0);
        send_job(msls_pkg::DUR_W'(7), 1'b1);
    endtask

    task automatic test_count_limits();
        set_servers('0);
        send_job(msls_pkg::DUR_W'(3), 1'b0);
        send_job(msls_pkg::DUR_W'(4), 1'b1);
        set_servers('1);
        send_job(msls_pkg::DUR_W'(1), 1'b0);
        send_job(msls_pkg::DUR_W'(2), 1'b1);
        set_servers(msls_pkg::CFG_W'(msls_pkg::MAX_SERVERS + 1));
        send_job('1, 1'b1);
    endtask

    task automatic test_count_change_mid_batch();
        set_servers(msls_pkg::CFG_W'(4));
        send_job(msls_pkg::DUR_W'(10), 1'b0);
        send_job(msls_pkg::DUR_W'(20), 1'b0);
        send_job(msls_pkg::DUR_W'(30), 1'b0);
        set_servers(msls_pkg::CFG_W'(2));
        send_job(msls_pkg::DUR_W'(5), 1'b0);
        send_job(msls_pkg::DUR_W'(6), 1'b1);
        set_servers(msls_pkg::CFG_W'(1));
        send_job(msls_pkg::DUR_W'(8), 1'b0);
        set_servers(msls_pkg::CFG_W'(3));
        send_job(msls_pkg::DUR_W'(9), 1'b0);
        send_job(msls_pkg::DUR_W'(1), 1'b1);
    endtask

    task automatic test_random_batches();
        int left;
        int len;
        int change_at;
        int n;
        left = RANDOM_JOBS;
        while (left > 0) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0) set_servers(pick_server_count());
            n = servers_active(servers_cfg);
            if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 2 * n + 4);
            else len = $urandom_range(1, 80);
            if (len > left) len = left;
            change_at = -1;
            if (len > 1 && $urandom_range(0, 7) == 0) change_at = $urandom_range(1, len - 1);
            for (int k = 0; k < len; k++) begin
                if (k == change_at) set_servers(pick_server_count());
                send_job(pick_duration(), k == len - 1);
            end
            left -= len;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin : run
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_server();
        test_equal_and_zero();
        test_count_limits();
        test_count_change_mid_batch();
        test_random_batches();
        settle();
        $display("%0d jobs scheduled, %0d batch reports compared", jobs_sent, reports_seen);
        $display("%0d distinct server count settings used", $countones(counts_tried));
        if (failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
